// ===== src/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
`default_nettype none
package qrs_pkg;

    // Width of every root part: signed fixed point.
    localparam int ROOT_W = 41;

    typedef enum logic [2:0] {
        CLS_LIN_NONE = 3'd0,
        CLS_LIN_ONE  = 3'd1,
        CLS_ALL_REAL = 3'd2,
        CLS_DOUBLE   = 3'd3,
        CLS_TWO_REAL = 3'd4,
        CLS_CPLX     = 3'd5
    } t_root_class;

endpackage
`default_nettype wire

// ===== src/qrs_sqrt_pipe.sv =====
// Pipelined restoring integer square root, one root bit per stage.
`default_nettype none
module qrs_sqrt_pipe import qrs_pkg::*; #(
    parameter int RW  = 66,
    parameter int SBW = 8,
    localparam int SW = RW / 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [RW-1:0]  i_rad,
    input  wire logic [SBW-1:0] i_side,
    output logic                o_valid,
    output logic [SW-1:0]       o_root,
    output logic [SBW-1:0]      o_side
);

    logic           r_v    [SW];
    logic [RW-1:0]  r_rad  [SW];
    logic [SW:0]    r_rem  [SW];
    logic [SW-1:0]  r_q    [SW];
    logic [SBW-1:0] r_side [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic           v_in;
        logic [RW-1:0]  rad_in;
        logic [SW:0]    rem_in;
        logic [SW-1:0]  q_in;
        logic [SBW-1:0] side_in;
        logic [SW+2:0]  cur;
        logic [SW+2:0]  trial;
        logic [SW+2:0]  diff;
        logic           ge;
        logic [SW:0]    n_rem;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down two radicand bits, try appending a one to the root
        assign cur   = {rem_in, rad_in[RW-1 -: 2]};
        assign trial = {1'b0, q_in, 2'b01};
        assign diff  = cur - trial;
        assign ge    = (cur >= trial);
        assign n_rem = ge ? diff[SW:0] : cur[SW:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= rad_in << 2;
                r_rem[k]  <= n_rem;
                r_q[k]    <= {q_in[SW-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_q[SW-1];
    assign o_side  = r_side[SW-1];

endmodule
`default_nettype wire

// ===== src/qrs_div_pipe.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
`default_nettype none
module qrs_div_pipe import qrs_pkg::*; #(
    parameter int NW  = 34,
    parameter int DW  = 17,
    parameter int SBW = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DW-1:0]  i_den,
    input  wire logic [SBW-1:0] i_side,
    output logic                o_valid,
    output logic [NW-1:0]       o_quot,
    output logic [SBW-1:0]      o_side
);

    logic           r_v    [NW];
    logic [NW-1:0]  r_num  [NW];
    logic [DW-1:0]  r_den  [NW];
    logic [DW-1:0]  r_rem  [NW];
    logic [NW-1:0]  r_q    [NW];
    logic [SBW-1:0] r_side [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic           v_in;
        logic [NW-1:0]  num_in;
        logic [DW-1:0]  den_in;
        logic [DW-1:0]  rem_in;
        logic [NW-1:0]  q_in;
        logic [SBW-1:0] side_in;
        logic [DW:0]    cur;
        logic [DW:0]    diff;
        logic           ge;
        logic [DW-1:0]  n_rem;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign rem_in  = '0;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        assign cur   = {rem_in, num_in[NW-1]};
        assign diff  = cur - {1'b0, den_in};
        assign ge    = (cur >= {1'b0, den_in});
        assign n_rem = ge ? diff[DW-1:0] : cur[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= num_in << 1;
                r_den[k]  <= den_in;
                r_rem[k]  <= n_rem;
                r_q[k]    <= {q_in[NW-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_q[NW-1];
    assign o_side  = r_side[NW-1];

endmodule
`default_nettype wire

// ===== src/quadratic_root_solver.sv =====
// Top level of the pipelined quadratic equation root solver.
// Usage:
//  - Input channel i_valid/o_ready carries one item: signed coefficients
//    a, b, c of a*x^2 + b*x + c = 0. Output channel o_valid/i_ready returns
//    one item per input: class code, discriminant and two complex roots in
//    signed fixed point with FRAC_BITS fraction bits, truncated toward zero
//    and saturated to the root field.
//  - Throughput: one item per cycle while the receiver keeps taking them.
//  - SW is the square-root pipeline depth (one root bit per stage) and NW
//    the divider depth (one quotient bit per stage). At the default widths
//    SW = 33 and NW = 34.
//  - Stages: products, discriminant and class, square root, numerators,
//    three dividers in lockstep, saturation into the output register.
//  - A skid register behind the output register keeps the pipeline moving
//    while one finished item waits; when both hold an item the whole pipe
//    freezes and o_ready drops, so nothing is lost or repeated.
//  - Reset (synchronous, active low) clears all valid bits; items in flight
//    are dropped and no item is presented afterwards until new input.
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16,
    localparam int DW = 2 * COEF_WIDTH + 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [COEF_WIDTH-1:0] i_coef_a,
    input  wire logic [COEF_WIDTH-1:0] i_coef_b,
    input  wire logic [COEF_WIDTH-1:0] i_coef_c,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [2:0]                 o_root_class,
    output logic [DW-1:0]              o_disc_value,
    output logic [ROOT_W-1:0]          o_first_real,
    output logic [ROOT_W-1:0]          o_first_imag,
    output logic [ROOT_W-1:0]          o_second_real,
    output logic [ROOT_W-1:0]          o_second_imag
);

    localparam int CW   = COEF_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int SW   = (DW + 2 * F + 1) / 2;    // root bits
    localparam int RW   = 2 * SW;                  // radicand bits
    localparam int PW   = CW + F + 1;              // scaled coefficient
    localparam int DNW  = CW + 1;                  // denominator
    localparam int NW   = ((SW > CW + F - 1) ? SW : CW + F - 1) + 1;
    localparam int NSW  = NW + 1;
    localparam int EW   = (NSW > ROOT_W) ? NSW : ROOT_W;
    localparam int SQSB = 3 + DW + 2 * PW + DNW;
    localparam int D1SB = 3 + DW + 1;

    localparam logic signed [EW-1:0] RHI =
        {{(EW - ROOT_W + 1){1'b0}}, {(ROOT_W - 1){1'b1}}};
    localparam logic signed [EW-1:0] RLO =
        {{(EW - ROOT_W + 1){1'b1}}, {(ROOT_W - 1){1'b0}}};

    function automatic logic [ROOT_W-1:0] sat_root(input logic signed [NSW-1:0] v);
        logic signed [EW-1:0] w;
        w = EW'(v);
        if (w > RHI) begin
            return RHI[ROOT_W-1:0];
        end else if (w < RLO) begin
            return RLO[ROOT_W-1:0];
        end
        return w[ROOT_W-1:0];
    endfunction

    // whole pipe advances unless the skid register is occupied
    logic en;
    logic r_skid_v;
    logic r_out_v;
    assign en      = !r_skid_v;
    assign o_ready = en;

    // ---- stage 1: products ----
    logic                         r_s1_v;
    logic signed [CW-1:0]         r_s1_a, r_s1_b, r_s1_c;
    logic signed [2*CW-1:0]       r_s1_bb, r_s1_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_a  <= i_coef_a;
            r_s1_b  <= i_coef_b;
            r_s1_c  <= i_coef_c;
            r_s1_bb <= $signed(i_coef_b) * $signed(i_coef_b);
            r_s1_ac <= $signed(i_coef_a) * $signed(i_coef_c);
        end
    end

    // ---- stage 2: discriminant, class, scaled terms ----
    logic signed [DW-1:0]  n_disc;
    logic                  a_zero, b_zero, c_zero;
    t_root_class           n_cls;
    logic signed [DW-1:0]  n_disc_out;
    logic [DW-1:0]         n_mag;
    logic signed [PW-1:0]  n_nb, n_lin;
    logic signed [DNW-1:0] n_den;

    assign n_disc = DW'(r_s1_bb) - (DW'(r_s1_ac) <<< 2);
    assign a_zero = (r_s1_a == '0);
    assign b_zero = (r_s1_b == '0);
    assign c_zero = (r_s1_c == '0);

    always_comb begin
        if (a_zero) begin
            if (b_zero) begin
                n_cls = c_zero ? CLS_ALL_REAL : CLS_LIN_NONE;
            end else begin
                n_cls = CLS_LIN_ONE;
            end
        end else if (n_disc == '0) begin
            n_cls = CLS_DOUBLE;
        end else if (n_disc[DW-1]) begin
            n_cls = CLS_CPLX;
        end else begin
            n_cls = CLS_TWO_REAL;
        end
        n_disc_out = a_zero ? '0 : n_disc;
        n_mag      = n_disc_out[DW-1] ? DW'(-n_disc_out) : DW'(n_disc_out);
        n_nb       = -(PW'(r_s1_b) <<< F);
        n_lin      = b_zero ? '0 : -(PW'(r_s1_c) <<< F);
        if (!a_zero) begin
            n_den = DNW'(r_s1_a) <<< 1;
        end else if (b_zero) begin
            n_den = DNW'(1);
        end else begin
            n_den = DNW'(r_s1_b);
        end
    end

    logic                  r_s2_v;
    t_root_class           r_s2_cls;
    logic signed [DW-1:0]  r_s2_disc;
    logic [DW-1:0]         r_s2_mag;
    logic signed [PW-1:0]  r_s2_nb, r_s2_lin;
    logic signed [DNW-1:0] r_s2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_cls  <= n_cls;
            r_s2_disc <= n_disc_out;
            r_s2_mag  <= n_mag;
            r_s2_nb   <= n_nb;
            r_s2_lin  <= n_lin;
            r_s2_den  <= n_den;
        end
    end

    // ---- square root of |D| * 2^(2F) ----
    logic [RW-1:0]   sq_rad;
    logic            sq_v;
    logic [SW-1:0]   sq_root;
    logic [SQSB-1:0] sq_side;

    assign sq_rad = RW'(r_s2_mag) << (2 * F);

    qrs_sqrt_pipe #(.RW(RW), .SBW(SQSB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_rad   (sq_rad),
        .i_side  ({r_s2_cls, r_s2_disc, r_s2_nb, r_s2_lin, r_s2_den}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---- numerator stage ----
    t_root_class           q_cls;
    logic signed [DW-1:0]  q_disc;
    logic signed [PW-1:0]  q_nb, q_lin;
    logic signed [DNW-1:0] q_den;
    logic signed [NSW-1:0] s_x, nb_x, n1, n2, n3;
    logic [NW-1:0]         n_m1, n_m2, n_m3;
    logic [DNW-1:0]        n_dm;

    assign {q_cls, q_disc, q_nb, q_lin, q_den} = sq_side;
    assign s_x  = $signed({{(NSW - SW){1'b0}}, sq_root});
    assign nb_x = NSW'(q_nb);

    always_comb begin
        case (q_cls)
            CLS_DOUBLE, CLS_TWO_REAL: begin
                n1 = nb_x + s_x;
                n2 = nb_x - s_x;
                n3 = '0;
            end
            CLS_CPLX: begin
                n1 = nb_x;
                n2 = nb_x;
                n3 = s_x;
            end
            default: begin
                // linear classes: numerator is zero when b is zero
                n1 = NSW'(q_lin);
                n2 = NSW'(q_lin);
                n3 = '0;
            end
        endcase
        n_m1 = n1[NSW-1] ? NW'(-n1) : NW'(n1);
        n_m2 = n2[NSW-1] ? NW'(-n2) : NW'(n2);
        n_m3 = n3[NSW-1] ? NW'(-n3) : NW'(n3);
        n_dm = q_den[DNW-1] ? DNW'(-q_den) : DNW'(q_den);
    end

    logic              r_n_v;
    t_root_class       r_n_cls;
    logic [DW-1:0]     r_n_disc;
    logic [NW-1:0]     r_n_m1, r_n_m2, r_n_m3;
    logic [DNW-1:0]    r_n_dm;
    logic              r_n_s1, r_n_s2, r_n_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (en) begin
            r_n_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_cls  <= q_cls;
            r_n_disc <= q_disc;
            r_n_m1   <= n_m1;
            r_n_m2   <= n_m2;
            r_n_m3   <= n_m3;
            r_n_dm   <= n_dm;
            r_n_s1   <= n1[NSW-1] ^ q_den[DNW-1];
            r_n_s2   <= n2[NSW-1] ^ q_den[DNW-1];
            r_n_s3   <= n3[NSW-1] ^ q_den[DNW-1];
        end
    end

    // ---- three dividers in lockstep ----
    logic            d1_v, d2_v, d3_v;
    logic [NW-1:0]   d1_q, d2_q, d3_q;
    logic [D1SB-1:0] d1_side;
    logic            d2_sg, d3_sg;

    qrs_div_pipe #(.NW(NW), .DW(DNW), .SBW(D1SB)) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_v),
        .i_num   (r_n_m1),
        .i_den   (r_n_dm),
        .i_side  ({r_n_cls, r_n_disc, r_n_s1}),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_side)
    );

    qrs_div_pipe #(.NW(NW), .DW(DNW), .SBW(1)) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_v),
        .i_num   (r_n_m2),
        .i_den   (r_n_dm),
        .i_side  (r_n_s2),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_sg)
    );

    qrs_div_pipe #(.NW(NW), .DW(DNW), .SBW(1)) u_div_imag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_v),
        .i_num   (r_n_m3),
        .i_den   (r_n_dm),
        .i_side  (r_n_s3),
        .o_valid (d3_v),
        .o_quot  (d3_q),
        .o_side  (d3_sg)
    );

    // ---- signs and saturation ----
    logic                  fin_v;
    logic [2:0]            fin_cls;
    logic [DW-1:0]         fin_disc;
    logic                  d1_sg;
    logic signed [NSW-1:0] v1, v2, v3;
    logic [ROOT_W-1:0]     n_r1, n_i1, n_r2, n_i2;

    assign fin_v = d1_v & d2_v & d3_v;
    assign {fin_cls, fin_disc, d1_sg} = d1_side;
    assign v1 = d1_sg ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});
    assign v2 = d2_sg ? -$signed({1'b0, d2_q}) : $signed({1'b0, d2_q});
    assign v3 = d3_sg ? -$signed({1'b0, d3_q}) : $signed({1'b0, d3_q});
    assign n_r1 = sat_root(v1);
    assign n_r2 = sat_root(v2);
    assign n_i1 = sat_root(v3);
    assign n_i2 = sat_root(-v3);

    // ---- output register and skid ----
    logic [2:0]        r_out_cls, r_skid_cls;
    logic [DW-1:0]     r_out_disc, r_skid_disc;
    logic [ROOT_W-1:0] r_out_r1, r_out_i1, r_out_r2, r_out_i2;
    logic [ROOT_W-1:0] r_skid_r1, r_skid_i1, r_skid_r2, r_skid_i2;
    logic              load_out, load_skid, skid_to_out;

    assign skid_to_out = r_skid_v && i_ready;
    assign load_out    = en && (!r_out_v || i_ready);
    assign load_skid   = en && r_out_v && !i_ready && fin_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (skid_to_out) begin
                r_skid_v <= 1'b0;
            end else if (load_out) begin
                r_out_v <= fin_v;
            end else if (load_skid) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (skid_to_out) begin
            r_out_cls  <= r_skid_cls;
            r_out_disc <= r_skid_disc;
            r_out_r1   <= r_skid_r1;
            r_out_i1   <= r_skid_i1;
            r_out_r2   <= r_skid_r2;
            r_out_i2   <= r_skid_i2;
        end else if (load_out) begin
            r_out_cls  <= fin_cls;
            r_out_disc <= fin_disc;
            r_out_r1   <= n_r1;
            r_out_i1   <= n_i1;
            r_out_r2   <= n_r2;
            r_out_i2   <= n_i2;
        end
        if (load_skid) begin
            r_skid_cls  <= fin_cls;
            r_skid_disc <= fin_disc;
            r_skid_r1   <= n_r1;
            r_skid_i1   <= n_i1;
            r_skid_r2   <= n_r2;
            r_skid_i2   <= n_i2;
        end
    end

    assign o_valid       = r_out_v;
    assign o_root_class  = r_out_cls;
    assign o_disc_value  = r_out_disc;
    assign o_first_real  = r_out_r1;
    assign o_first_imag  = r_out_i1;
    assign o_second_real = r_out_r2;
    assign o_second_imag = r_out_i2;

    // ---- checks ----
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds an item while output is empty");

    a_real_pair_no_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_class == CLS_DOUBLE || o_root_class == CLS_TWO_REAL)
        |-> (o_first_imag == '0) && (o_second_imag == '0))
        else $error("real roots carry an imaginary part");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_class == CLS_LIN_NONE || o_root_class == CLS_ALL_REAL)
        |-> (o_first_real == '0) && (o_second_real == '0) && (o_disc_value == '0))
        else $error("degenerate equation gives nonzero result");

endmodule
`default_nettype wire
